// ===== rtl/wpp_pkg.sv =====
// Shared constants and types for the windowed peak picker.
package wpp_pkg;

  localparam int unsigned WINDOW_SIZE = 11;
  localparam int unsigned CENTER_POS  = 5;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned FRAME_MAX   = 65536;

  // The centre is clamped into the window.
  localparam int unsigned CENTER_EFF =
      (CENTER_POS < WINDOW_SIZE) ? CENTER_POS : (WINDOW_SIZE - 1);

  // The frame position counter holds values up to FRAME_MAX - 1.
  localparam int unsigned IDX_W   = $clog2(FRAME_MAX);
  // Result values reach FRAME_MAX (a saturated peak count).
  localparam int unsigned VALUE_W = $clog2(FRAME_MAX + 1);

  typedef enum logic {
    KIND_PEAK  = 1'b0,
    KIND_COUNT = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [VALUE_W-1:0]   value;
    logic                 last;
  } result_t;

endpackage

// ===== rtl/wpp_cell.sv =====
// One delay-line cell: holds a sample and its threshold and compares against the centre.
module wpp_cell (
  input  logic                                  clk_i,
  input  logic                                  shift_i,
  input  logic signed [wpp_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic signed [wpp_pkg::SAMPLE_BITS-1:0] threshold_i,
  input  logic signed [wpp_pkg::SAMPLE_BITS-1:0] centre_i,
  output logic signed [wpp_pkg::SAMPLE_BITS-1:0] sample_o,
  output logic signed [wpp_pkg::SAMPLE_BITS-1:0] threshold_o,
  output logic                                  gt_o
);
  import wpp_pkg::*;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] threshold_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sample_q    <= sample_i;
      threshold_q <= threshold_i;
    end
  end

  assign sample_o    = sample_q;
  assign threshold_o = threshold_q;
  // Strictly greater: equal samples do not suppress the centre.
  assign gt_o        = (sample_q > centre_i);

endmodule

// ===== rtl/wpp_result_fifo.sv =====
// Two-entry result queue between the peak evaluation and the output channel.
module wpp_result_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wpp_pkg::result_t push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output wpp_pkg::result_t pop_data_o
);
  import wpp_pkg::*;

  result_t     mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        do_push, do_pop;

  // Space is judged on the registered fill level only, so the output
  // handshake never reaches back combinationally to the input side.
  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign do_push = push_i && push_ready_o;
  assign do_pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/windowed_peak_picker_core.sv =====
// Top level of the windowed peak picker: delay-line cells, peak evaluation and result queue.
//
// Usage: each input transaction on sample_i/threshold_i/frame_end_i (valid/ready) shifts one
// sample and its threshold into a chain of WINDOW_SIZE cells. Once a frame has delivered
// WINDOW_SIZE samples, the cell at the centre is tested in the cycle after the transaction:
// it is a peak when it is at least its own threshold and no other cell holds a strictly
// greater sample. A peak yields a result transaction of kind "peak" carrying the 1-based
// frame position of the centre sample. A transaction with frame_end_i set also yields a
// "count" result with the number of peaks of the frame, then the frame position and the
// count restart from zero. run_last_o marks the final result caused by one input.
// A result passes from the evaluation stage register into the result queue before it is
// offered on the output channel.
// Throughput: one input transaction per cycle while each causes at most one result and the
// evaluation stage can hand it over; an input that causes both a peak and a count holds the
// evaluation stage until both are queued, since the result queue takes one result per cycle.
// When the receiver stalls, the two-entry result queue fills and in_ready_o falls once the
// evaluation stage cannot hand over its result; input readiness depends on registered
// evaluation and queue state only. Reset (rst_ni, asynchronous, active low) empties the queue
// and the evaluation stage and clears the frame position and peak count; the cell contents
// need no reset because no test is made before a frame has refilled the whole window.
module windowed_peak_picker_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [wpp_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic signed [wpp_pkg::SAMPLE_BITS-1:0] threshold_i,
  input  logic                                  frame_end_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  result_kind_o,
  output logic [wpp_pkg::VALUE_W-1:0]           result_value_o,
  output logic                                  run_last_o
);
  import wpp_pkg::*;

  // Delay-line wiring: index 0 is the newest sample.
  logic signed [SAMPLE_BITS-1:0] samp_w [WINDOW_SIZE];
  logic signed [SAMPLE_BITS-1:0] thr_w  [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0]        gt_w;
  logic [WINDOW_SIZE-1:0]        gt_others;
  logic signed [SAMPLE_BITS-1:0] centre;

  logic                 in_accept;

  // Frame position of the next input transaction.
  logic [IDX_W-1:0]     index_q, index_d;
  // Evaluation stage: the item whose samples were last shifted in.
  logic                 eval_valid_q, eval_valid_d;
  logic [IDX_W-1:0]     eval_idx_q;
  logic                 eval_last_q;
  // Set once the peak result of a frame-ending item has been queued.
  logic                 eval_phase_q, eval_phase_d;
  logic [VALUE_W-1:0]   peak_total_q, peak_total_d;

  logic                 window_full;
  logic                 is_peak;
  logic                 need_peak;
  logic                 has_result;
  logic                 push;
  logic                 push_ready;
  logic                 eval_done;
  result_t              push_data;
  result_t              pop_data;

  assign in_accept = in_valid_i && in_ready_o;

  // The chain of cells; every cell compares itself with the centre sample.
  assign centre = samp_w[CENTER_EFF];

  for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
    if (g == 0) begin : g_head
      wpp_cell u_cell (
        .clk_i       (clk_i),
        .shift_i     (in_accept),
        .sample_i    (sample_i),
        .threshold_i (threshold_i),
        .centre_i    (centre),
        .sample_o    (samp_w[g]),
        .threshold_o (thr_w[g]),
        .gt_o        (gt_w[g])
      );
    end else begin : g_body
      wpp_cell u_cell (
        .clk_i       (clk_i),
        .shift_i     (in_accept),
        .sample_i    (samp_w[g-1]),
        .threshold_i (thr_w[g-1]),
        .centre_i    (centre),
        .sample_o    (samp_w[g]),
        .threshold_o (thr_w[g]),
        .gt_o        (gt_w[g])
      );
    end
  end

  // The centre never suppresses itself.
  always_comb begin
    gt_others             = gt_w;
    gt_others[CENTER_EFF] = 1'b0;
  end

  // Peak decision on the registered window of the item in evaluation.
  assign window_full = (eval_idx_q >= IDX_W'(WINDOW_SIZE - 1));
  assign is_peak     = window_full && (centre >= thr_w[CENTER_EFF]) && !(|gt_others);
  assign need_peak   = is_peak && !eval_phase_q;
  assign has_result  = need_peak || eval_last_q;
  assign push        = eval_valid_q && has_result && push_ready;

  // The item leaves evaluation when it has nothing to report, or when its final
  // result goes into the queue.
  assign eval_done = eval_valid_q &&
                     (!has_result || (push_ready && !(need_peak && eval_last_q)));

  assign in_ready_o = !eval_valid_q || eval_done;

  always_comb begin
    if (need_peak) begin
      push_data.kind  = KIND_PEAK;
      push_data.value = VALUE_W'(eval_idx_q) - VALUE_W'(CENTER_EFF - 1);
      push_data.last  = !eval_last_q;
    end else begin
      push_data.kind  = KIND_COUNT;
      push_data.value = peak_total_q;
      push_data.last  = 1'b1;
    end
  end

  always_comb begin
    index_d = index_q;
    if (in_accept) begin
      if (frame_end_i) begin
        index_d = '0;
      end else if (index_q < IDX_W'(FRAME_MAX - 1)) begin
        index_d = index_q + IDX_W'(1);
      end
    end

    eval_valid_d = eval_valid_q;
    if (in_accept) begin
      eval_valid_d = 1'b1;
    end else if (eval_done) begin
      eval_valid_d = 1'b0;
    end

    eval_phase_d = eval_phase_q;
    if (eval_done) begin
      eval_phase_d = 1'b0;
    end else if (push && need_peak && eval_last_q) begin
      eval_phase_d = 1'b1;
    end

    peak_total_d = peak_total_q;
    if (push) begin
      if (need_peak) begin
        if (peak_total_q < VALUE_W'(FRAME_MAX)) begin
          peak_total_d = peak_total_q + VALUE_W'(1);
        end
      end else begin
        peak_total_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q      <= '0;
      eval_valid_q <= 1'b0;
      eval_phase_q <= 1'b0;
      peak_total_q <= '0;
    end else begin
      index_q      <= index_d;
      eval_valid_q <= eval_valid_d;
      eval_phase_q <= eval_phase_d;
      peak_total_q <= peak_total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      eval_idx_q  <= index_q;
      eval_last_q <= frame_end_i;
    end
  end

  wpp_result_fifo u_result_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (out_valid_o),
    .pop_ready_i  (out_ready_i),
    .pop_data_o   (pop_data)
  );

  assign result_kind_o  = logic'(pop_data.kind);
  assign result_value_o = pop_data.value;
  assign run_last_o     = pop_data.last;

`ifndef SYNTHESIS
  a_phase_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_phase_q |-> eval_valid_q)
    else $error("second result pending without an item in evaluation");

  a_phase_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_phase_q |-> eval_last_q)
    else $error("second result pending for an item that does not end a frame");

  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_total_q <= VALUE_W'(FRAME_MAX))
    else $error("peak count beyond saturation");

  a_count_clears_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !need_peak) |=> (peak_total_q == '0))
    else $error("peak count not cleared after the frame count was queued");

  a_shift_frees_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && eval_valid_q) |-> eval_done)
    else $error("window shifted while the previous item was still in evaluation");
`endif

endmodule

// ===== dv/windowed_peak_picker_core_test.sv =====
// Self-checking testbench for the windowed peak picker core.
module windowed_peak_picker_core_test;
  import wpp_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 16'sh8000;
  localparam int unsigned RANDOM_ITEMS   = 1825;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned IDLE_LIMIT     = 2000;

  typedef enum int unsigned {
    STYLE_WIDE,
    STYLE_NARROW,
    STYLE_EXTREME
  } sample_style_e;

  // Mirrors the delay lines, frame position and peak count of the block, and holds the
  // results still owed by it in arrival order.
  class peak_predictor;
    logic signed [SAMPLE_BITS-1:0] sample_line[WINDOW_SIZE];
    logic signed [SAMPLE_BITS-1:0] thresh_line[WINDOW_SIZE];
    int unsigned frame_pos;
    int unsigned peaks_found;
    result_t     awaited_results[$];
    int unsigned errors = 0;

    function new();
      clear_frame();
    endfunction

    function void clear_frame();
      int i;
      for (i = 0; i < WINDOW_SIZE; i++) begin
        sample_line[i] = '0;
        thresh_line[i] = '0;
      end
      frame_pos   = 0;
      peaks_found = 0;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    function void note_sample(logic signed [SAMPLE_BITS-1:0] sample,
                              logic signed [SAMPLE_BITS-1:0] thresh, logic frame_end);
      int i;
      logic signed [SAMPLE_BITS-1:0] centre;
      bit is_peak;
      result_t r;
      for (i = WINDOW_SIZE - 1; i > 0; i--) begin
        sample_line[i] = sample_line[i-1];
        thresh_line[i] = thresh_line[i-1];
      end
      sample_line[0] = sample;
      thresh_line[0] = thresh;
      // The centre is only judged once the frame has filled the whole window.
      if (frame_pos >= WINDOW_SIZE - 1) begin
        centre  = sample_line[CENTER_EFF];
        is_peak = centre >= thresh_line[CENTER_EFF];
        for (i = 0; i < WINDOW_SIZE; i++)
          if (i != CENTER_EFF && sample_line[i] > centre) is_peak = 1'b0;
        if (is_peak) begin
          r.kind  = KIND_PEAK;
          r.value = VALUE_W'(frame_pos - CENTER_EFF + 1);
          r.last  = !frame_end;
          awaited_results.push_back(r);
          if (peaks_found < FRAME_MAX) peaks_found++;
        end
      end
      // The position sticks at its top value in an over-long frame.
      if (frame_pos < FRAME_MAX - 1) frame_pos++;
      if (frame_end) begin
        r.kind  = KIND_COUNT;
        r.value = VALUE_W'(peaks_found);
        r.last  = 1'b1;
        awaited_results.push_back(r);
        clear_frame();
      end
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch: %s got %0d want %0d", what, got, want);
      errors++;
    endtask

    task check_result(kind_e kind, logic [VALUE_W-1:0] value, logic last);
      result_t want;
      if (awaited_results.size() == 0) begin
        report("unexpected result, value", value, 0);
        return;
      end
      want = awaited_results.pop_front();
      if (kind !== want.kind) report("result_kind", kind, want.kind);
      if (value !== want.value) report("result_value", value, want.value);
      if (last !== want.last) report("run_last", last, want.last);
    endtask
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic signed [SAMPLE_BITS-1:0] sample_i = '0;
  logic signed [SAMPLE_BITS-1:0] threshold_i = '0;
  logic                          frame_end_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          result_kind_o;
  logic [VALUE_W-1:0]            result_value_o;
  logic                          run_last_o;

  peak_predictor tracker;
  bit            tx_idle_on = 1'b1;
  bit            rx_idle_on = 1'b1;
  int unsigned   rx_wait = 0;
  int unsigned   random_sent = 0;

  windowed_peak_picker_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .threshold_i   (threshold_i),
    .frame_end_i   (frame_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .result_value_o(result_value_o),
    .run_last_o    (run_last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(sample_style_e style);
    case (style)
      STYLE_WIDE:   return SAMPLE_BITS'($urandom);
      STYLE_NARROW: return SAMPLE_BITS'($urandom_range(0, 6) - 3);
      default: begin
        case ($urandom_range(0, 4))
          0:       return S_MAX;
          1:       return S_MIN;
          2:       return '0;
          3:       return '1;
          default: return SAMPLE_BITS'($urandom);
        endcase
      end
    endcase
  endfunction

  // Thresholds mostly sit at or under the sample so that peaks are frequent.
  function automatic logic signed [SAMPLE_BITS-1:0] draw_threshold(
      logic signed [SAMPLE_BITS-1:0] s);
    int unsigned r;
    int tv;
    r = $urandom_range(0, 99);
    if (r < 10) return S_MIN;
    if (r < 60) begin
      tv = int'(s) - int'($urandom_range(0, 300));
      if (tv < int'(S_MIN)) tv = int'(S_MIN);
      return SAMPLE_BITS'(tv);
    end
    if (r < 75) return s;
    return SAMPLE_BITS'($urandom);
  endfunction

  task automatic send_item(input logic signed [SAMPLE_BITS-1:0] s,
                           input logic signed [SAMPLE_BITS-1:0] t, input logic fe);
    int unsigned gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_i    <= s;
    threshold_i <= t;
    frame_end_i <= fe;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_sample(s, t, fe);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic directed_items();
    int i;
    // A frame of one item ends before the window fills: count of zero.
    send_item(S_MAX, S_MIN, 1'b1);
    // A lone maximum equal to its threshold, found on the frame's last item.
    for (i = 0; i < WINDOW_SIZE; i++)
      send_item(i == 5 ? S_MAX : S_MIN, (i == 5 || i % 2 == 1) ? S_MAX : S_MIN,
                i == WINDOW_SIZE - 1);
    // A flat run: ties pass, except where the threshold sits above the sample.
    for (i = 0; i < 13; i++)
      send_item('0, i == 6 ? 16'sh0001 : 16'shffff, i == 12);
  endtask

  task automatic random_frame();
    int unsigned r, len, k;
    sample_style_e style;
    logic signed [SAMPLE_BITS-1:0] s;
    r = $urandom_range(0, 99);
    if (r < 10) len = $urandom_range(1, 4);
    else if (r < 85) len = $urandom_range(5, 40);
    else len = $urandom_range(41, 150);
    r = $urandom_range(0, 99);
    style = (r < 45) ? STYLE_WIDE : (r < 80) ? STYLE_NARROW : STYLE_EXTREME;
    for (k = 0; k < len; k++) begin
      s = draw_sample(style);
      send_item(s, draw_threshold(s), k == len - 1);
      random_sent++;
    end
  endtask

  initial begin : result_sink
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        tracker.check_result(kind_e'(result_kind_o), result_value_o, run_last_o);
      if (rx_wait == 0 && rx_idle_on && $urandom_range(0, 3) == 0) rx_wait = pick_gap();
      if (rx_wait != 0) begin
        rx_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Ends the run when neither channel has moved a transaction for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    wait (rst_ni);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    tracker = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_items();
    hold_until_drained();
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) tx_idle_on = !tx_idle_on;
      if ($urandom_range(0, 9) == 0) rx_idle_on = !rx_idle_on;
      random_frame();
      if ($urandom_range(0, 19) == 0) hold_until_drained();
    end
    hold_until_drained();
    if (tracker.pending() != 0) tracker.report("results never seen", tracker.pending(), 0);
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wpp_pkg.sv
rtl/wpp_cell.sv
rtl/wpp_result_fifo.sv
rtl/windowed_peak_picker_core.sv
dv/windowed_peak_picker_core_test.sv
